// File: design/pw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pw_pkg: shared types and constants for the 2-D pooling window block
// Holds the sample and index widths, the line store geometry, the pooling
// modes, the back end state encoding and the structs that join the modules.
// ----------------------------------------------------------------------------
package pw_pkg;

    localparam int SampleBits = 16;
    localparam int IdxBits    = 10;
    localparam int DimBits    = 11;
    localparam int WinBits    = 4;
    localparam int ModeBits   = 2;
    localparam int SlotBits   = 3;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 1024;
    localparam int MaxWindow  = 8;
    localparam int StoreDepth = MaxWindow * MaxWidth;
    localparam int AddrBits   = SlotBits + IdxBits;
    localparam int SumBits    = SampleBits + 2 * SlotBits;
    localparam int SqBits     = 2 * SlotBits + 1;
    localparam int StepBits   = 5;
    localparam int CfgAddrBits = 3;

    localparam logic [CfgAddrBits-1:0] RegWidth  = 3'd0;
    localparam logic [CfgAddrBits-1:0] RegHeight = 3'd1;
    localparam logic [CfgAddrBits-1:0] RegWindow = 3'd2;
    localparam logic [CfgAddrBits-1:0] RegStep   = 3'd3;
    localparam logic [CfgAddrBits-1:0] RegMode   = 3'd4;

    localparam logic [ModeBits-1:0] ModeMax = 2'd0;
    localparam logic [ModeBits-1:0] ModeMin = 2'd1;
    localparam logic [ModeBits-1:0] ModeAvg = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_LOAD,
        ST_DIV,
        ST_PUSH
    } t_state;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [DimBits-1:0]  width;
        logic [DimBits-1:0]  height;
        logic [WinBits-1:0]  win;
        logic [WinBits-1:0]  step;
        logic [ModeBits-1:0] mode;
    } t_cfg;

    // One classified sample, passed from the front end to the back end.
    typedef struct packed {
        logic [SampleBits-1:0] sample;
        logic [IdxBits-1:0]    col;
        logic [SlotBits-1:0]   slot;
        logic [IdxBits-1:0]    ox;
        logic [IdxBits-1:0]    oy;
        logic                  last;
        logic                  hit;
    } t_item;

endpackage : pw_pkg
`default_nettype wire

// File: design/pw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pw_front: raster position tracking and window classification
// Follows column and row of each sample, keeps the stride phase on both axes
// and marks samples that close a window, with its output indices.
// ----------------------------------------------------------------------------
module pw_front
    import pw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_restart,
    input  wire logic                  i_accept,
    input  wire logic [SampleBits-1:0] i_sample,
    output t_item                      o_item
);

    logic [IdxBits-1:0]  r_col, n_col, r_row, n_row;
    logic [WinBits-1:0]  r_cph, n_cph, r_rph, n_rph;
    logic [IdxBits-1:0]  r_ox, n_ox, r_oy, n_oy;

    logic [DimBits-1:0]  col_p1, row_p1, ncol_p1, nrow_p1;
    logic [DimBits-1:0]  win_ext;
    logic [DimBits:0]    col_s, row_s;
    logic                col_wrap, row_wrap;
    logic [WinBits-1:0]  cph_inc, rph_inc;

    always_comb begin
        win_ext  = {{(DimBits-WinBits){1'b0}}, i_cfg.win};
        col_p1   = {1'b0, r_col} + 1'b1;
        row_p1   = {1'b0, r_row} + 1'b1;
        col_wrap = (col_p1 >= i_cfg.width);
        row_wrap = (row_p1 >= i_cfg.height);
        col_s    = {2'b0, r_col} + {{(DimBits+1-WinBits){1'b0}}, i_cfg.step};
        row_s    = {2'b0, r_row} + {{(DimBits+1-WinBits){1'b0}}, i_cfg.step};
        cph_inc  = (r_cph + 1'b1 == i_cfg.step) ? '0 : r_cph + 1'b1;
        rph_inc  = (r_rph + 1'b1 == i_cfg.step) ? '0 : r_rph + 1'b1;

        n_col = col_wrap ? '0 : col_p1[IdxBits-1:0];
        n_row = r_row;
        n_cph = r_cph;
        n_ox  = r_ox;
        n_rph = r_rph;
        n_oy  = r_oy;
        ncol_p1 = {1'b0, n_col} + 1'b1;
        if (ncol_p1 == win_ext) begin
            n_cph = '0;
            n_ox  = '0;
        end else if (ncol_p1 > win_ext) begin
            n_cph = cph_inc;
            n_ox  = r_ox + ((cph_inc == '0) ? 1'b1 : 1'b0);
        end
        nrow_p1 = row_p1;
        if (col_wrap) begin
            n_row   = row_wrap ? '0 : row_p1[IdxBits-1:0];
            nrow_p1 = {1'b0, n_row} + 1'b1;
            if (nrow_p1 == win_ext) begin
                n_rph = '0;
                n_oy  = '0;
            end else if (nrow_p1 > win_ext) begin
                n_rph = rph_inc;
                n_oy  = r_oy + ((rph_inc == '0) ? 1'b1 : 1'b0);
            end
        end
    end

    always_comb begin
        o_item.sample = i_sample;
        o_item.col    = r_col;
        o_item.slot   = r_row[SlotBits-1:0];
        o_item.ox     = r_ox;
        o_item.oy     = r_oy;
        o_item.hit    = (col_p1 >= win_ext) && (r_cph == '0) &&
                        (row_p1 >= win_ext) && (r_rph == '0);
        // No further window fits to the right or below.
        o_item.last   = (col_s >= {1'b0, i_cfg.width}) &&
                        (row_s >= {1'b0, i_cfg.height});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_cph <= '0;
            r_rph <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_cph <= n_cph;
            r_rph <= n_rph;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
        end
    end

endmodule : pw_front
`default_nettype wire

// File: design/pw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pw_queue: four-entry queue of classified samples
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module pw_queue
    import pw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    t_item       r_buf [0:3];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {2'b0, do_push} - {2'b0, do_pop};
        end
    end

endmodule : pw_queue
`default_nettype wire

// File: design/pw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pw_back: line store, window scan, average divider and result register
// Writes each sample into the row ring; on a window-closing sample it reads
// the F by F window one entry per cycle, reduces it and holds the result.
// ----------------------------------------------------------------------------
module pw_back
    import pw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_q_empty,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [SampleBits-1:0]      o_pooled_value,
    output logic [IdxBits-1:0]         o_out_col,
    output logic [IdxBits-1:0]         o_out_row,
    output logic                       o_plane_last
);

    t_state r_state, n_state;

    logic [SampleBits-1:0] r_mem [0:StoreDepth-1];
    logic [SampleBits-1:0] r_rd_data;
    logic                  r_rd_vld;

    t_item                 r_cur;
    logic [SlotBits-1:0]   r_i, r_j;
    logic signed [SampleBits-1:0] r_max, r_min;
    logic signed [SumBits-1:0]    r_sum;
    logic [SumBits-1:0]    r_dvd;
    logic [SqBits-1:0]     r_rem;
    logic                  r_neg;
    logic [StepBits-1:0]   r_dcnt;

    logic                  r_out_vld;
    logic [SampleBits-1:0] r_out_val;
    logic [IdxBits-1:0]    r_out_col, r_out_row;
    logic                  r_out_last;

    logic                  mem_wr, rd_issue, scan_end, push_ok;
    logic [SlotBits-1:0]   f_m1, rd_slot;
    logic [IdxBits-1:0]    rd_col;
    logic [AddrBits-1:0]   rd_addr;
    logic [SqBits-1:0]     fsq;
    logic [SqBits:0]       d_try;
    logic [SqBits:0]       d_sub;
    logic signed [SampleBits-1:0] rd_s;
    logic [SampleBits-1:0] res;
    logic [SumBits-1:0]    sum_abs;

    always_comb begin
        f_m1     = i_cfg.win[SlotBits-1:0] - 1'b1;
        fsq      = SqBits'(i_cfg.win * i_cfg.win);
        rd_slot  = r_cur.slot - f_m1 + r_i;
        rd_col   = r_cur.col - {{(IdxBits-SlotBits){1'b0}}, f_m1}
                 + {{(IdxBits-SlotBits){1'b0}}, r_j};
        rd_addr  = {rd_slot, rd_col};
        scan_end = (r_i == f_m1) && (r_j == f_m1);
        push_ok  = !r_out_vld || i_pop;
        rd_s     = $signed(r_rd_data);
        sum_abs  = r_sum[SumBits-1] ? SumBits'(-r_sum) : SumBits'(r_sum);
        d_try    = {r_rem, r_dvd[SumBits-1]};
        d_sub    = d_try - {1'b0, fsq};
        case (i_cfg.mode)
            ModeMin: res = r_min;
            ModeAvg: res = r_neg ? SampleBits'(-r_dvd) : r_dvd[SampleBits-1:0];
            default: res = r_max;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && i_q_item.hit) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = (i_cfg.mode == ModeAvg) ? ST_LOAD : ST_PUSH;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_dcnt == StepBits'(1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_q_pop  = 1'b0;
        mem_wr   = 1'b0;
        rd_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
                mem_wr  = !i_q_empty;
            end
            ST_SCAN:  rd_issue = 1'b1;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[{i_q_item.slot, i_q_item.col}] <= i_q_item.sample;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_issue;
            if (r_state == ST_PUSH && push_ok) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_cur <= i_q_item;
            r_i   <= '0;
            r_j   <= '0;
            r_max <= {1'b1, {(SampleBits-1){1'b0}}};
            r_min <= {1'b0, {(SampleBits-1){1'b1}}};
            r_sum <= '0;
        end
        if (rd_issue) begin
            if (r_j == f_m1) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_rd_vld) begin
            if (rd_s > r_max) begin
                r_max <= rd_s;
            end
            if (rd_s < r_min) begin
                r_min <= rd_s;
            end
            r_sum <= r_sum + SumBits'(rd_s);
        end
        if (r_state == ST_LOAD) begin
            r_dvd  <= sum_abs;
            r_neg  <= r_sum[SumBits-1];
            r_rem  <= '0;
            r_dcnt <= StepBits'(SumBits);
        end
        // Restoring division, one quotient bit per cycle.
        if (r_state == ST_DIV) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (!d_sub[SqBits]) begin
                r_rem <= d_sub[SqBits-1:0];
                r_dvd <= {r_dvd[SumBits-2:0], 1'b1};
            end else begin
                r_rem <= d_try[SqBits-1:0];
                r_dvd <= {r_dvd[SumBits-2:0], 1'b0};
            end
        end
        if (r_state == ST_PUSH && push_ok) begin
            r_out_val  <= res;
            r_out_col  <= r_cur.ox;
            r_out_row  <= r_cur.oy;
            r_out_last <= r_cur.last;
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_pooled_value = r_out_val;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;
    assign o_plane_last   = r_out_last;

`ifndef SYNTH
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i <= f_m1 && r_j <= f_m1))
        else $error("window scan index beyond window");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && r_out_vld && !i_pop) |=> (r_state == ST_PUSH))
        else $error("result left push state while output register busy");
    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE && !r_rd_vld))
        else $error("queue popped during window work");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_IDLE && !r_out_vld))
        else $error("back end not idle after reset");
`endif

endmodule : pw_back
`default_nettype wire

// File: design/pooling_2d_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pooling_2d_window: streaming 2-D max, min or average pooling
// Samples arrive in raster order; each window-closing sample yields one
// pooled value with its output column, row and an end-of-plane flag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   input     i_push / o_full         i_sample
//   result    o_empty / i_pop         o_pooled_value, o_out_col, o_out_row,
//                                     o_plane_last
//   config    i_cfg_we                i_cfg_addr, i_cfg_data
//
// A sample that closes no window is only written to the line store; one
// that closes a window also starts a scan of the F by F window, paced by
// the single read port of the line store, and in average mode the
// one-bit-per-cycle divider. The front end and a four-beat queue keep
// taking samples while the back end works. Reset is synchronous and active
// low and clears the counters, the queue and the state machine; the line
// store is not cleared, since a window only reads entries written earlier in
// the same plane. A full result register stalls the back end in place.
// ----------------------------------------------------------------------------
module pooling_2d_window
    import pw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CfgAddrBits-1:0] i_cfg_addr,
    input  wire logic [DimBits-1:0]     i_cfg_data,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic [SampleBits-1:0]  i_sample,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output logic [SampleBits-1:0]       o_pooled_value,
    output logic [IdxBits-1:0]          o_out_col,
    output logic [IdxBits-1:0]          o_out_row,
    output logic                        o_plane_last
);

    // Raw configuration registers, as written.
    logic [DimBits-1:0]  r_width, r_height;
    logic [WinBits-1:0]  r_win, r_step;
    logic [ModeBits-1:0] r_mode;

    t_cfg  cfg;
    t_item front_item, q_item;
    logic  accept, q_empty, q_pop;

    // Clamp the registers to their legal ranges: zero sizes act as one,
    // oversize values saturate, and the unused mode code acts as maximum.
    always_comb begin
        cfg.width  = (r_width == '0) ? DimBits'(1) :
                     (r_width > DimBits'(MaxWidth)) ? DimBits'(MaxWidth) : r_width;
        cfg.height = (r_height == '0) ? DimBits'(1) :
                     (r_height > DimBits'(MaxHeight)) ? DimBits'(MaxHeight) : r_height;
        cfg.win    = (r_win == '0) ? WinBits'(1) :
                     (r_win > WinBits'(MaxWindow)) ? WinBits'(MaxWindow) : r_win;
        cfg.step   = (r_step == '0) ? WinBits'(1) : r_step;
        cfg.mode   = (r_mode == ModeMin || r_mode == ModeAvg) ? r_mode : ModeMax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DimBits'(1);
            r_height <= DimBits'(1);
            r_win    <= WinBits'(2);
            r_step   <= WinBits'(2);
            r_mode   <= ModeMax;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegWidth:  r_width  <= i_cfg_data;
                RegHeight: r_height <= i_cfg_data;
                RegWindow: r_win    <= i_cfg_data[WinBits-1:0];
                RegStep:   r_step   <= i_cfg_data[WinBits-1:0];
                RegMode:   r_mode   <= i_cfg_data[ModeBits-1:0];
                default:   r_mode   <= r_mode;
            endcase
        end
    end

    assign accept = i_push && !o_full;

    // Any configuration write restarts the plane at column and row zero.
    pw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (i_cfg_we),
        .i_accept  (accept),
        .i_sample  (i_sample),
        .o_item    (front_item)
    );

    pw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    pw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_empty      (q_empty),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_pooled_value (o_pooled_value),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_plane_last   (o_plane_last)
    );

endmodule : pooling_2d_window
`default_nettype wire
